@@ rtl/core/dcl_pkg.sv @@
package dcl_pkg;

   // default sizes
   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;

   // fixed field widths
   localparam int RADIUS_W = 34;
   localparam int COUNT_W  = 11;
   localparam int LABEL_W  = 10;
   localparam int QIDX_W   = 10;

   // register indexes
   localparam logic CSR_RADIUS_SQ = 1'b0;
   localparam logic CSR_MIN_COUNT = 1'b1;

   // item kinds
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [COUNT_W-1:0] MIN_COUNT_RST = 11'd4;

endpackage

@@ rtl/core/dcl_dist_cell.sv @@
module dcl_dist_cell #(
   parameter int CB = dcl_pkg::COORD_BITS_DEF,
   parameter int SW = 2 * dcl_pkg::COORD_BITS_DEF + 2,
   parameter int TW = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            valid_in,
   input  logic [TW-1:0]   tag_in,
   input  logic [3*CB-1:0] ref_in,
   input  logic [3*CB-1:0] pt_in,
   input  logic [SW-1:0]   sum_in,
   output logic            valid_out,
   output logic [TW-1:0]   tag_out,
   output logic [3*CB-1:0] ref_out,
   output logic [3*CB-1:0] pt_out,
   output logic [SW-1:0]   sum_out
);

   logic            valid_ff;
   logic [TW-1:0]   tag_ff;
   logic [3*CB-1:0] ref_ff;
   logic [3*CB-1:0] pt_ff;
   logic [SW-1:0]   sum_ff;
   logic signed [CB:0]       diff;
   logic signed [2*CB+1:0]   sq;

   // square of the lowest lane difference
   always_comb begin
      diff = (CB+1)'($signed(ref_in[CB-1:0])) - (CB+1)'($signed(pt_in[CB-1:0]));
      sq   = (2*CB+2)'(diff) * (2*CB+2)'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // lanes shift down so the next cell sees the next axis
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      ref_ff <= ref_in >> CB;
      pt_ff  <= pt_in >> CB;
      sum_ff <= sum_in + SW'($unsigned(sq));
   end

   assign valid_out = valid_ff;
   assign tag_out   = tag_ff;
   assign ref_out   = ref_ff;
   assign pt_out    = pt_ff;
   assign sum_out   = sum_ff;

endmodule

@@ rtl/core/density_cluster_labeler.sv @@
// Density clustering of 3-D points over a squared-distance neighborhood.
// Items enter on start when busy is low. A load item (req_func = 0) stores
// one point and, without req_last, leaves the block idle; with req_last set
// the block then clusters all stored points and holds busy until done.
// A query item (req_func = 1) gives one result: rsp_valid pulses for one
// cycle once the query state has read the stores and the result is
// registered. The receiver cannot stall. Loads beyond MAX_POINTS store
// nothing; their last mark still clusters. The user must write registers
// through csr_we / csr_index / csr_wdata only while idle; the block does
// not enforce this. Clustering streams every point past a chain of three
// distance cells, one pair per cycle. The core pass streams all points past
// each point in turn; expansion streams them past each core point taken off
// the stack and checks the visited and core flags of each seed candidate.
// Reset clears the point count and registers; the stores need no clearing.
module density_cluster_labeler #(
   parameter int MAX_POINTS = dcl_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = dcl_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_func,
   input  logic signed [15:0]           req_coord_x,
   input  logic signed [15:0]           req_coord_y,
   input  logic signed [15:0]           req_coord_z,
   input  logic [dcl_pkg::QIDX_W-1:0]   req_query_index,
   input  logic                         req_last,
   output logic                         rsp_valid,
   output logic [dcl_pkg::QIDX_W-1:0]   rsp_point_index,
   output logic [dcl_pkg::LABEL_W-1:0]  rsp_cluster_label,
   output logic                         rsp_is_noise,
   output logic                         rsp_is_core,
   output logic                         rsp_out_of_range,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [dcl_pkg::RADIUS_W-1:0] csr_wdata
);

   localparam int CB   = COORD_BITS;
   localparam int IW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int SW   = 2 * CB + 2;
   localparam int TW   = IW + 2;
   localparam int LW   = dcl_pkg::LABEL_W;
   localparam int QW   = (CNTW > dcl_pkg::QIDX_W) ? CNTW : dcl_pkg::QIDX_W;
   localparam int MW   = (CNTW > dcl_pkg::COUNT_W) ? CNTW : dcl_pkg::COUNT_W;
   localparam int CMPW = (SW > dcl_pkg::RADIUS_W) ? SW : dcl_pkg::RADIUS_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_QRY    = 4'd1;
   localparam logic [3:0] ST_C1_LD  = 4'd2;
   localparam logic [3:0] ST_C1_CAP = 4'd3;
   localparam logic [3:0] ST_C1_RUN = 4'd4;
   localparam logic [3:0] ST_C1_END = 4'd5;
   localparam logic [3:0] ST_SEED   = 4'd6;
   localparam logic [3:0] ST_CHK    = 4'd7;
   localparam logic [3:0] ST_POP    = 4'd8;
   localparam logic [3:0] ST_PADDR  = 4'd9;
   localparam logic [3:0] ST_C2_CAP = 4'd10;
   localparam logic [3:0] ST_C2_RUN = 4'd11;

   // memories
   logic [3*CB-1:0] coord_mem [MAX_POINTS];
   logic            core_mem  [MAX_POINTS];
   logic            vis_mem   [MAX_POINTS];
   logic [LW-1:0]   label_mem [MAX_POINTS];
   logic [IW-1:0]   stk_mem   [MAX_POINTS];

   logic [3*CB-1:0] coord_rd_ff;
   logic            core_rd_ff;
   logic            vis_rd_ff;
   logic [LW-1:0]   label_rd_ff;
   logic [IW-1:0]   stk_rd_ff;

   // control registers
   logic [3:0]      state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] i_ff, i_in;
   logic [CNTW-1:0] j_ff, j_in;
   logic [CNTW-1:0] sp_ff, sp_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0]   nc_ff, nc_in;
   logic [IW-1:0]   p_ff, p_in;
   logic [IW-1:0]   j_iss_ff;
   logic            iss_v_ff, iss_v_in;
   logic [3*CB-1:0] ref_ff, ref_in;
   logic [dcl_pkg::RADIUS_W-1:0] radius_ff;
   logic [dcl_pkg::COUNT_W-1:0]  min_count_ff;
   logic [dcl_pkg::QIDX_W-1:0]   q_ff, q_in;
   logic            oor_ff, oor_in;

   // result registers
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dcl_pkg::QIDX_W-1:0]  rsp_index_ff;
   logic [LW-1:0]               rsp_label_ff, rsp_label_in;
   logic                        rsp_noise_ff, rsp_noise_in;
   logic                        rsp_core_ff, rsp_core_in;
   logic                        rsp_oor_ff;

   // memory ports
   logic [IW-1:0]   rd_addr;
   logic [IW-1:0]   stk_raddr;
   logic [IW-1:0]   wr_addr;
   logic [IW-1:0]   stk_waddr;
   logic            coord_we, core_we, vis_we, label_we, stk_we;
   logic            core_wd, vis_wd;
   logic [LW-1:0]   label_wd;
   logic [IW-1:0]   stk_wd;
   logic [3*CB-1:0] coord_wd;

   // distance chain
   logic            v0, v1, v2;
   logic [TW-1:0]   t0, t1, t2;
   logic [3*CB-1:0] r0, r1, r2, q0, q1, q2;
   logic [SW-1:0]   s0, s1, s2;
   logic [IW-1:0]   act_j;
   logic            act_core, act_vis, near;
   logic            pipe_idle, issue;

   dcl_dist_cell #(.CB(CB), .SW(SW), .TW(TW)) u_cell0 (
      .clock(clock), .reset(reset),
      .valid_in(iss_v_ff), .tag_in({j_iss_ff, core_rd_ff, vis_rd_ff}),
      .ref_in(ref_ff), .pt_in(coord_rd_ff), .sum_in('0),
      .valid_out(v0), .tag_out(t0), .ref_out(r0), .pt_out(q0), .sum_out(s0)
   );

   dcl_dist_cell #(.CB(CB), .SW(SW), .TW(TW)) u_cell1 (
      .clock(clock), .reset(reset),
      .valid_in(v0), .tag_in(t0), .ref_in(r0), .pt_in(q0), .sum_in(s0),
      .valid_out(v1), .tag_out(t1), .ref_out(r1), .pt_out(q1), .sum_out(s1)
   );

   dcl_dist_cell #(.CB(CB), .SW(SW), .TW(TW)) u_cell2 (
      .clock(clock), .reset(reset),
      .valid_in(v1), .tag_in(t1), .ref_in(r1), .pt_in(q1), .sum_in(s1),
      .valid_out(v2), .tag_out(t2), .ref_out(r2), .pt_out(q2), .sum_out(s2)
   );

   // end of chain: neighbor test
   always_comb begin
      act_j     = t2[TW-1:2];
      act_core  = t2[1];
      act_vis   = t2[0];
      near      = CMPW'(s2) <= CMPW'(radius_ff);
      pipe_idle = !iss_v_ff && !v0 && !v1 && !v2;
      issue     = j_ff < count_ff;
      stk_raddr = IW'(sp_ff - CNTW'(1));
      coord_wd  = {CB'($unsigned(req_coord_z)), CB'($unsigned(req_coord_y)),
                   CB'($unsigned(req_coord_x))};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sp_in        = sp_ff;
      cnt_in       = cnt_ff;
      nc_in        = nc_ff;
      p_in         = p_ff;
      iss_v_in     = 1'b0;
      ref_in       = ref_ff;
      q_in         = q_ff;
      oor_in       = oor_ff;
      rsp_valid_in = 1'b0;
      rsp_label_in = rsp_label_ff;
      rsp_noise_in = rsp_noise_ff;
      rsp_core_in  = rsp_core_ff;
      rd_addr      = IW'(j_ff);
      wr_addr      = act_j;
      stk_waddr    = IW'(sp_ff);
      stk_wd       = act_j;
      coord_we     = 1'b0;
      core_we      = 1'b0;
      vis_we       = 1'b0;
      label_we     = 1'b0;
      stk_we       = 1'b0;
      core_wd      = 1'b0;
      vis_wd       = 1'b1;
      label_wd     = nc_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = IW'(req_query_index);
            if (start) begin
               if (req_func == dcl_pkg::FUNC_QUERY) begin
                  q_in     = req_query_index;
                  oor_in   = QW'(req_query_index) >= QW'(count_ff);
                  state_in = ST_QRY;
               end else begin
                  if (count_ff < CNTW'(MAX_POINTS)) begin
                     wr_addr  = IW'(count_ff);
                     coord_we = 1'b1;
                     core_we  = 1'b1;
                     vis_we   = 1'b1;
                     vis_wd   = 1'b0;
                     count_in = count_ff + CNTW'(1);
                  end
                  if (req_last) begin
                     i_in     = '0;
                     state_in = ST_C1_LD;
                  end
               end
            end
         end
         ST_QRY: begin
            rsp_valid_in = 1'b1;
            if (oor_ff) begin
               rsp_label_in = '0;
               rsp_noise_in = 1'b0;
               rsp_core_in  = 1'b0;
            end else begin
               rsp_label_in = vis_rd_ff ? label_rd_ff : '0;
               rsp_noise_in = !vis_rd_ff;
               rsp_core_in  = core_rd_ff;
            end
            state_in = ST_IDLE;
         end
         // core pass: count neighbors of point i
         ST_C1_LD: begin
            rd_addr  = IW'(i_ff);
            state_in = ST_C1_CAP;
         end
         ST_C1_CAP: begin
            ref_in   = coord_rd_ff;
            j_in     = '0;
            cnt_in   = '0;
            state_in = ST_C1_RUN;
         end
         ST_C1_RUN: begin
            if (issue) begin
               iss_v_in = 1'b1;
               j_in     = j_ff + CNTW'(1);
            end
            if (v2 && act_j != IW'(i_ff) && near) begin
               cnt_in = cnt_ff + CNTW'(1);
            end
            if (!issue && pipe_idle) begin
               state_in = ST_C1_END;
            end
         end
         ST_C1_END: begin
            wr_addr = IW'(i_ff);
            core_we = 1'b1;
            core_wd = MW'(cnt_ff) >= MW'(min_count_ff);
            vis_we  = 1'b1;
            vis_wd  = 1'b0;
            i_in    = i_ff + CNTW'(1);
            if (i_ff + CNTW'(1) == count_ff) begin
               i_in     = '0;
               nc_in    = '0;
               state_in = ST_SEED;
            end else begin
               state_in = ST_C1_LD;
            end
         end
         // expansion: look for the next unvisited core seed
         ST_SEED: begin
            rd_addr = IW'(i_ff);
            if (i_ff == count_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (vis_rd_ff || !core_rd_ff) begin
               i_in     = i_ff + CNTW'(1);
               state_in = ST_SEED;
            end else begin
               wr_addr   = IW'(i_ff);
               vis_we    = 1'b1;
               label_we  = 1'b1;
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wd    = IW'(i_ff);
               sp_in     = CNTW'(1);
               state_in  = ST_POP;
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               nc_in    = nc_ff + LW'(1);
               i_in     = i_ff + CNTW'(1);
               state_in = ST_SEED;
            end else begin
               sp_in    = sp_ff - CNTW'(1);
               state_in = ST_PADDR;
            end
         end
         ST_PADDR: begin
            rd_addr  = stk_rd_ff;
            p_in     = stk_rd_ff;
            state_in = ST_C2_CAP;
         end
         ST_C2_CAP: begin
            ref_in   = coord_rd_ff;
            j_in     = '0;
            state_in = ST_C2_RUN;
         end
         ST_C2_RUN: begin
            if (issue) begin
               iss_v_in = 1'b1;
               j_in     = j_ff + CNTW'(1);
            end
            if (v2 && act_j != p_ff && !act_vis && near) begin
               vis_we   = 1'b1;
               label_we = 1'b1;
               if (act_core && sp_ff < CNTW'(MAX_POINTS)) begin
                  stk_we = 1'b1;
                  sp_in  = sp_ff + CNTW'(1);
               end
            end
            if (!issue && pipe_idle) begin
               state_in = ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= '0;
         min_count_ff <= dcl_pkg::MIN_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_v_ff     <= iss_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == dcl_pkg::CSR_RADIUS_SQ) begin
            radius_ff <= csr_wdata;
         end
         if (csr_we && csr_index == dcl_pkg::CSR_MIN_COUNT) begin
            min_count_ff <= csr_wdata[dcl_pkg::COUNT_W-1:0];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      sp_ff        <= sp_in;
      cnt_ff       <= cnt_in;
      nc_ff        <= nc_in;
      p_ff         <= p_in;
      j_iss_ff     <= IW'(j_ff);
      ref_ff       <= ref_in;
      q_ff         <= q_in;
      oor_ff       <= oor_in;
      rsp_index_ff <= q_ff;
      rsp_label_ff <= rsp_label_in;
      rsp_noise_ff <= rsp_noise_in;
      rsp_core_ff  <= rsp_core_in;
      rsp_oor_ff   <= oor_ff;
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (coord_we) begin
         coord_mem[wr_addr] <= coord_wd;
      end
      if (core_we) begin
         core_mem[wr_addr] <= core_wd;
      end
      if (vis_we) begin
         vis_mem[wr_addr] <= vis_wd;
      end
      if (label_we) begin
         label_mem[wr_addr] <= label_wd;
      end
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wd;
      end
   end

   // registered memory reads
   always_ff @(posedge clock) begin
      coord_rd_ff <= coord_mem[rd_addr];
      core_rd_ff  <= core_mem[rd_addr];
      vis_rd_ff   <= vis_mem[rd_addr];
      label_rd_ff <= label_mem[rd_addr];
      stk_rd_ff   <= stk_mem[stk_raddr];
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_index   = rsp_index_ff;
   assign rsp_cluster_label = rsp_label_ff;
   assign rsp_is_noise      = rsp_noise_ff;
   assign rsp_is_core       = rsp_core_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

endmodule

@@ verif/density_cluster_labeler_test.sv @@
`timescale 1ns / 1ps

module density_cluster_labeler_test;

   localparam int NPTS = dcl_pkg::MAX_POINTS_DEF;
   localparam longint unsigned RADIUS_MAX = 64'd12884508675;

   typedef struct {
      logic                          func;
      logic signed [15:0]            x;
      logic signed [15:0]            y;
      logic signed [15:0]            z;
      logic [dcl_pkg::QIDX_W-1:0]    qidx;
      logic                          last;
      bit                            typed;
      logic [dcl_pkg::LABEL_W-1:0]   label;
      logic                          noise;
      logic                          core;
      logic                          oor;
   } item_type;

   typedef struct {
      logic [dcl_pkg::QIDX_W-1:0]  idx;
      logic [dcl_pkg::LABEL_W-1:0] label;
      logic                        noise;
      logic                        core;
      logic                        oor;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = dcl_pkg::FUNC_LOAD;
   logic signed [15:0] req_coord_x = '0;
   logic signed [15:0] req_coord_y = '0;
   logic signed [15:0] req_coord_z = '0;
   logic [dcl_pkg::QIDX_W-1:0] req_query_index = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic [dcl_pkg::QIDX_W-1:0] rsp_point_index;
   logic [dcl_pkg::LABEL_W-1:0] rsp_cluster_label;
   logic rsp_is_noise;
   logic rsp_is_core;
   logic rsp_out_of_range;
   logic csr_we = 1'b0;
   logic csr_index = dcl_pkg::CSR_RADIUS_SQ;
   logic [dcl_pkg::RADIUS_W-1:0] csr_wdata = '0;

   density_cluster_labeler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z), .req_query_index(req_query_index),
      .req_last(req_last), .rsp_valid(rsp_valid), .rsp_point_index(rsp_point_index),
      .rsp_cluster_label(rsp_cluster_label), .rsp_is_noise(rsp_is_noise),
      .rsp_is_core(rsp_is_core), .rsp_out_of_range(rsp_out_of_range),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the point memory and clustering state
   logic signed [15:0] px [NPTS];
   logic signed [15:0] py [NPTS];
   logic signed [15:0] pz [NPTS];
   bit                 core_q [NPTS];
   bit                 seen_q [NPTS];
   logic [dcl_pkg::LABEL_W-1:0] label_q [NPTS];
   int                 stack_q [NPTS];
   int                 n_stored = 0;
   longint unsigned    radius_q = 0;
   int                 min_q = int'(dcl_pkg::MIN_COUNT_RST);

   answer_type pending_answers [$];
   int      errors = 0;
   int      burst_left = 0;
   logic signed [15:0] centers [6];

   function automatic bit near_pair(int a, int b);
      longint dx, dy, dz;
      dx = longint'(px[a]) - longint'(px[b]);
      dy = longint'(py[a]) - longint'(py[b]);
      dz = longint'(pz[a]) - longint'(pz[b]);
      return longint'(dx * dx + dy * dy + dz * dz) <= longint'(radius_q);
   endfunction

   // core pass, then stack-driven expansion from each unvisited core seed
   function automatic void recluster();
      int cnt, sp, p;
      logic [dcl_pkg::LABEL_W-1:0] cl;
      for (int i = 0; i < n_stored; i++) begin
         cnt = 0;
         for (int j = 0; j < n_stored; j++)
            if (j != i && near_pair(i, j)) cnt++;
         core_q[i] = (cnt >= min_q);
         seen_q[i] = 0;
      end
      cl = '0;
      for (int i = 0; i < n_stored; i++) begin
         if (seen_q[i] || !core_q[i]) continue;
         label_q[i] = cl;
         seen_q[i] = 1;
         stack_q[0] = i;
         sp = 1;
         while (sp > 0) begin
            sp--;
            p = stack_q[sp];
            for (int j = 0; j < n_stored; j++) begin
               if (j == p || seen_q[j] || !near_pair(p, j)) continue;
               label_q[j] = cl;
               seen_q[j] = 1;
               if (core_q[j]) begin
                  stack_q[sp] = j;
                  sp++;
               end
            end
         end
         cl++;
      end
   endfunction

   // update shadow state for an accepted item, queue the answer of a query
   function automatic void absorb(item_type it);
      answer_type a;
      if (it.func == dcl_pkg::FUNC_LOAD) begin
         if (n_stored < NPTS) begin
            px[n_stored] = it.x;
            py[n_stored] = it.y;
            pz[n_stored] = it.z;
            core_q[n_stored] = 0;
            seen_q[n_stored] = 0;
            label_q[n_stored] = '0;
            n_stored++;
         end
         if (it.last) recluster();
         return;
      end
      a.idx = it.qidx;
      if (int'(it.qidx) >= n_stored) begin
         a.label = '0; a.noise = 0; a.core = 0; a.oor = 1;
      end else begin
         a.label = seen_q[it.qidx] ? label_q[it.qidx] : '0;
         a.noise = !seen_q[it.qidx];
         a.core  = core_q[it.qidx];
         a.oor   = 0;
      end
      if (it.typed) begin
         a.label = it.label; a.noise = it.noise; a.core = it.core; a.oor = it.oor;
      end
      pending_answers = {pending_answers, a};
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            report("unexpected result, index", 64'(rsp_point_index), 64'(0));
         end else begin
            w = pending_answers.pop_front();
            if (rsp_point_index !== w.idx)
               report("point_index", 64'(rsp_point_index), 64'(w.idx));
            if (rsp_cluster_label !== w.label)
               report("cluster_label", 64'(rsp_cluster_label), 64'(w.label));
            if (rsp_is_noise !== w.noise)
               report("is_noise", 64'(rsp_is_noise), 64'(w.noise));
            if (rsp_is_core !== w.core)
               report("is_core", 64'(rsp_is_core), 64'(w.core));
            if (rsp_out_of_range !== w.oor)
               report("out_of_range", 64'(rsp_out_of_range), 64'(w.oor));
         end
      end
   end

   // present one item at the falling edge and hold it until taken
   task automatic issue(item_type it);
      start = 1'b1;
      req_func = it.func;
      req_coord_x = it.x;
      req_coord_y = it.y;
      req_coord_z = it.z;
      req_query_index = it.qidx;
      req_last = it.last;
      do @(posedge clock); while (busy);
      absorb(it);
      @(negedge clock);
   endtask

   // bursty sender: random gaps between random-length bursts
   task automatic send(item_type it);
      issue(it);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 40))
                                                  : int'($urandom_range(0, 8));
      end
   endtask

   task automatic settle();
      start = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [dcl_pkg::RADIUS_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == dcl_pkg::CSR_RADIUS_SQ) radius_q = 64'(val);
      else min_q = int'(val[dcl_pkg::COUNT_W-1:0]);
   endtask

   function automatic item_type load_item(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z, logic lst);
      item_type it;
      it = '{default: '0};
      it.func = dcl_pkg::FUNC_LOAD;
      it.x = x; it.y = y; it.z = z; it.last = lst;
      it.qidx = dcl_pkg::QIDX_W'($urandom);
      return it;
   endfunction

   function automatic item_type query_item(int idx);
      item_type it;
      it = '{default: '0};
      it.func = dcl_pkg::FUNC_QUERY;
      it.qidx = dcl_pkg::QIDX_W'(idx);
      it.x = 16'($urandom); it.y = 16'($urandom); it.z = 16'($urandom);
      it.last = 1'($urandom);
      return it;
   endfunction

   // mostly points scattered around a few blob centers, some anywhere
   function automatic item_type blob_point(logic lst);
      int c;
      if ($urandom_range(0, 7) == 0)
         return load_item(16'($urandom), 16'($urandom), 16'($urandom), lst);
      c = int'($urandom_range(0, 5));
      return load_item(16'(int'(centers[c]) + int'($urandom_range(0, 400)) - 200),
                       16'(int'(centers[(c + 1) % 6]) + int'($urandom_range(0, 400)) - 200),
                       16'(int'(centers[(c + 2) % 6]) + int'($urandom_range(0, 400)) - 200),
                       lst);
   endfunction

   function automatic item_type random_query();
      if ($urandom_range(0, 9) == 0 || n_stored == 0)
         return query_item(int'($urandom_range(0, 1023)));
      return query_item(int'($urandom_range(0, n_stored - 1)));
   endfunction

   // directed rows: typed answers where they are obvious
   function automatic item_type row(logic f, int x, int y, int z, int q, int lst,
                                    int typed, int lbl, int nz, int cr, int oor);
      item_type it;
      it.func = f; it.x = 16'(x); it.y = 16'(y); it.z = 16'(z);
      it.qidx = dcl_pkg::QIDX_W'(q); it.last = 1'(lst);
      it.typed = 1'(typed); it.label = dcl_pkg::LABEL_W'(lbl);
      it.noise = 1'(nz); it.core = 1'(cr); it.oor = 1'(oor);
      return it;
   endfunction

   item_type directed [$];

   function automatic void add_row(item_type it);
      directed = {directed, it};
   endfunction

   initial begin
      int batch [7];
      longint unsigned radii [7];
      int mins [7];
      batch = '{12, 20, 30, 60, 100, 80, 30};
      radii = '{RADIUS_MAX, 0, 150000, 60000, 250000, 90000, 120000};
      mins  = '{0, 1024, 2, 3, 1023, 4, 3};

      // query before any load, extremes, identical points forming one cluster
      add_row(row(dcl_pkg::FUNC_QUERY, 5, -5, 7, 0, 1, 1, 0, 0, 0, 1));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 1023, 0, 1, 0, 0, 0, 1));
      add_row(row(dcl_pkg::FUNC_LOAD, 32767, 32767, 32767, 1023, 0, 0, 0, 0, 0, 0));
      add_row(row(dcl_pkg::FUNC_LOAD, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 2, 0, 1, 0, 0, 0, 1));
      for (int k = 0; k < 5; k++)
         add_row(row(dcl_pkg::FUNC_LOAD, 0, 0, 0, 682, int'(k == 4), 0, 0, 0, 0, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 1, 0, 1, 0, 1, 0, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 2, 0, 1, 0, 0, 1, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, -1, -1, -1, 6, 1, 1, 0, 0, 1, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 7, 0, 1, 0, 0, 0, 1));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 341, 0, 1, 0, 0, 0, 1));
      // appended after clustering: reads as noise until the next last mark
      add_row(row(dcl_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 7, 0, 1, 0, 1, 0, 0));
      add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, 3, 0, 0, 0, 0, 0, 0));
      add_row(row(dcl_pkg::FUNC_LOAD, 1, 2, 3, 0, 1, 0, 0, 0, 0, 0));
      for (int k = 0; k < 9; k++)
         add_row(row(dcl_pkg::FUNC_QUERY, 0, 0, 0, k, 0, 0, 0, 0, 0, 0));

      repeat (7) @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send(directed[i]);

      // phases: new settings, a batch of points, then queries; all but the last add unclustered loads and more queries
      for (int ph = 0; ph < 7; ph++) begin
         settle();
         write_reg(dcl_pkg::CSR_RADIUS_SQ, dcl_pkg::RADIUS_W'(radii[ph]));
         write_reg(dcl_pkg::CSR_MIN_COUNT, dcl_pkg::RADIUS_W'(mins[ph]));
         foreach (centers[c]) centers[c] = 16'($urandom);
         for (int k = 0; k < batch[ph]; k++) begin
            if ($urandom_range(0, 15) == 0) send(random_query());
            send(blob_point(k == batch[ph] - 1));
         end
         repeat (20) send(random_query());
         if (ph < 6) begin
            repeat (3) send(blob_point(1'b0));
            repeat (6) send(query_item(int'($urandom_range(n_stored - 4, 1023))));
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("density_cluster_labeler_test: clean");
      else
         $display("density_cluster_labeler_test: errors");
      $finish;
   end

   initial begin
      #300ms;
      $display("density_cluster_labeler_test: errors");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/dcl_pkg.sv
rtl/core/dcl_dist_cell.sv
rtl/core/density_cluster_labeler.sv
verif/density_cluster_labeler_test.sv
